@@ sv/epsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsm_pkg: shared types and constants
// Item kinds, register indexes, field widths and reset values of the meter.
// ----------------------------------------------------------------------------
package epsm_pkg;

  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 16;
  localparam int PERIOD_W = 32;
  localparam int SPEED_W  = 29;
  localparam int STALL_W  = 8;
  localparam int SCALE_W  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam kind_t KIND_CAPTURE = 2'd0;
  localparam kind_t KIND_WRAP    = 2'd1;
  localparam kind_t KIND_READ    = 2'd2;

  localparam cfg_idx_t REG_RELOAD_SPAN = 3'd0;
  localparam cfg_idx_t REG_HALF_SPAN   = 3'd1;
  localparam cfg_idx_t REG_STALL_TICKS = 3'd2;
  localparam cfg_idx_t REG_DIR_INVERT  = 3'd3;
  localparam cfg_idx_t REG_SPEED_SCALE = 3'd4;

  localparam logic [COUNT_W-1:0] RESET_RELOAD_SPAN = 16'd10000;
  localparam logic [COUNT_W-1:0] RESET_HALF_SPAN   = 16'd5000;
  localparam logic [STALL_W-1:0] RESET_STALL_TICKS = 8'd4;
  localparam logic [SCALE_W-1:0] RESET_SPEED_SCALE = 24'd1000000;

  localparam logic signed [SPEED_W-1:0]  SPEED_MAX  = 29'sh0FFF_FFFF;
  localparam logic signed [SPEED_W-1:0]  SPEED_MIN  = 29'sh1000_0000;
  localparam logic signed [PERIOD_W-1:0] PERIOD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PERIOD_W-1:0] PERIOD_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

@@ sv/epsm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsm_if: item channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface epsm_in_if
  import epsm_pkg::*;
();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [COUNT_W-1:0] capture_count;
  logic               wrap_pending;
  logic               direction_level;

  modport source (output valid, kind, capture_count, wrap_pending, direction_level,
                  input ready);
  modport sink   (input valid, kind, capture_count, wrap_pending, direction_level,
                  output ready);
endinterface

interface epsm_out_if
  import epsm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [PERIOD_W-1:0] period_ticks;
  logic                       sample_taken;
  logic                       stall_flag;
  logic signed [SPEED_W-1:0]  speed_q8;
  logic                       speed_valid;

  modport source (output valid, period_ticks, sample_taken, stall_flag, speed_q8,
                  speed_valid, input ready);
  modport sink   (input valid, period_ticks, sample_taken, stall_flag, speed_q8,
                  speed_valid, output ready);
endinterface
`default_nettype wire

@@ sv/epsm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsm_div: serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module epsm_div #(
  parameter int DIV_W = 37
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign trial = {rem, quotient[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIV_W-2:0], ge};
      rem      <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ sv/encoder_period_speed_meter_top.sv @@
// ----------------------------------------------------------------------------
// Capture steps ST_CAP_MUL, ST_CAP_ADD, ST_CAP_SAT, ST_CAP_ACC, wrap tick
// ST_WRAP, read ST_RD_BEG, with samples ST_RD_AVG then ST_RD_SPD for a nonzero
// average; all end in ST_FIN, as does kind 3. DIV_W = 32+clog2(QUEUE_DEPTH+1),
// serial divider run for average then speed; one item at a time, next item
// taken as its result goes out. Sync reset loads register defaults, clears state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module encoder_period_speed_meter_top
  import epsm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  epsm_in_if.sink                    in_ch,
  epsm_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = PERIOD_W + CNT_W;
  localparam int DIV_W = SUM_W;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CAP_MUL = 4'd1;
  localparam logic [3:0] ST_CAP_ADD = 4'd2;
  localparam logic [3:0] ST_CAP_SAT = 4'd3;
  localparam logic [3:0] ST_CAP_ACC = 4'd4;
  localparam logic [3:0] ST_WRAP    = 4'd5;
  localparam logic [3:0] ST_RD_AVG  = 4'd6;
  localparam logic [3:0] ST_RD_SPD  = 4'd7;
  localparam logic [3:0] ST_FIN     = 4'd8;
  localparam logic [3:0] ST_RD_BEG  = 4'd9;

  logic [3:0] state;

  logic [COUNT_W-1:0] reload_span;
  logic [COUNT_W-1:0] half_span;
  logic [STALL_W-1:0] stall_ticks;
  logic               direction_invert;
  logic [SCALE_W-1:0] speed_scale;

  logic [COUNT_W-1:0]        wrap_counter;
  logic [COUNT_W-1:0]        last_edge_wrap;
  logic [COUNT_W-1:0]        last_capture;
  logic signed [SUM_W-1:0]   period_sum;
  logic [CNT_W-1:0]          sample_count;
  logic                      stall_seen;
  logic signed [SPEED_W-1:0] held_speed;

  logic [COUNT_W-1:0] cap_r;
  logic               pend_r;
  logic               dir_r;

  logic [32:0]          prod;
  logic signed [34:0]   praw;
  logic signed [PERIOD_W-1:0] res_period;
  logic                 res_taken;
  logic                 res_stall;
  logic                 res_valid;
  logic                 avg_neg;

  logic [COUNT_W:0]   wraps;
  logic [32:0]        mul;
  logic signed [34:0] pneg;
  logic               fits;
  logic [COUNT_W-1:0] wc_next;
  logic [COUNT_W-1:0] wrap_gap;
  logic [SUM_W-1:0]   sum_mag;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  assign in_ch.ready = (state == ST_IDLE);

  assign wraps    = {1'b0, wrap_counter - last_edge_wrap}
                  + (COUNT_W + 1)'(pend_r && (cap_r < half_span));
  assign mul      = wraps * reload_span;
  assign pneg     = (dir_r == direction_invert) ? -praw : praw;
  assign fits     = (pneg[34:31] == 4'b0000) || (pneg[34:31] == 4'b1111);
  assign wc_next  = wrap_counter + 1'b1;
  assign wrap_gap = wc_next - last_edge_wrap;
  assign sum_mag  = period_sum[SUM_W-1] ? -period_sum : period_sum;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = sum_mag;
    div_divisor  = {{(DIV_W-CNT_W){1'b0}}, sample_count};
    if (state == ST_RD_BEG) begin
      div_start = (sample_count != '0);
    end else if (state == ST_RD_AVG) begin
      div_start    = div_done && (div_quot != '0);
      div_dividend = {{(DIV_W-32){1'b0}}, speed_scale, 8'd0};
      div_divisor  = div_quot;
    end
  end

  epsm_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_span      <= RESET_RELOAD_SPAN;
      half_span        <= RESET_HALF_SPAN;
      stall_ticks      <= RESET_STALL_TICKS;
      direction_invert <= 1'b0;
      speed_scale      <= RESET_SPEED_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RELOAD_SPAN: reload_span      <= cfg_data[COUNT_W-1:0];
        REG_HALF_SPAN:   half_span        <= cfg_data[COUNT_W-1:0];
        REG_STALL_TICKS: stall_ticks      <= cfg_data[STALL_W-1:0];
        REG_DIR_INVERT:  direction_invert <= cfg_data[0];
        REG_SPEED_SCALE: speed_scale      <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      wrap_counter   <= '0;
      last_edge_wrap <= '0;
      last_capture   <= '0;
      period_sum     <= '0;
      sample_count   <= '0;
      stall_seen     <= 1'b0;
      held_speed     <= '0;
      out_ch.valid   <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && (state != ST_FIN)) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            cap_r      <= in_ch.capture_count;
            pend_r     <= in_ch.wrap_pending;
            dir_r      <= in_ch.direction_level;
            res_period <= '0;
            res_taken  <= 1'b0;
            res_stall  <= 1'b0;
            res_valid  <= 1'b0;
            case (in_ch.kind)
              KIND_CAPTURE: state <= ST_CAP_MUL;
              KIND_WRAP:    state <= ST_WRAP;
              KIND_READ:    state <= ST_RD_BEG;
              default:      state <= ST_FIN;
            endcase
          end
        end
        ST_CAP_MUL: begin
          prod  <= mul;
          state <= ST_CAP_ADD;
        end
        ST_CAP_ADD: begin
          praw  <= 35'(prod) + 35'(cap_r) - 35'(last_capture);
          state <= ST_CAP_SAT;
        end
        ST_CAP_SAT: begin
          res_period     <= fits ? pneg[PERIOD_W-1:0] : (pneg[34] ? PERIOD_MIN : PERIOD_MAX);
          last_capture   <= cap_r;
          last_edge_wrap <= wrap_counter;
          state          <= ST_CAP_ACC;
        end
        ST_CAP_ACC: begin
          if (sample_count < CNT_W'(QUEUE_DEPTH)) begin
            period_sum   <= period_sum
                          + {{(SUM_W-PERIOD_W){res_period[PERIOD_W-1]}}, res_period};
            sample_count <= sample_count + 1'b1;
            res_taken    <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_WRAP: begin
          wrap_counter <= wc_next;
          if (wrap_gap >= {{(COUNT_W-STALL_W){1'b0}}, stall_ticks}) begin
            stall_seen <= 1'b1;
            res_stall  <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_RD_BEG: begin
          avg_neg      <= period_sum[SUM_W-1];
          res_valid    <= 1'b1;
          period_sum   <= '0;
          sample_count <= '0;
          stall_seen   <= 1'b0;
          if (sample_count != '0) begin
            state <= ST_RD_AVG;
          end else begin
            if (stall_seen) begin
              held_speed <= '0;
            end
            state <= ST_FIN;
          end
        end
        ST_RD_AVG: begin
          if (div_done) begin
            if (div_quot == '0) begin
              held_speed <= SPEED_MAX;
              state      <= ST_FIN;
            end else begin
              state <= ST_RD_SPD;
            end
          end
        end
        ST_RD_SPD: begin
          if (div_done) begin
            if (div_quot[DIV_W-1:SPEED_W-1] != '0) begin
              held_speed <= avg_neg ? SPEED_MIN : SPEED_MAX;
            end else if (avg_neg) begin
              held_speed <= -div_quot[SPEED_W-1:0];
            end else begin
              held_speed <= div_quot[SPEED_W-1:0];
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && (!out_ch.valid || out_ch.ready)) begin
      out_ch.period_ticks <= res_period;
      out_ch.sample_taken <= res_taken;
      out_ch.stall_flag   <= res_stall;
      out_ch.speed_q8     <= res_valid ? held_speed : '0;
      out_ch.speed_valid  <= res_valid;
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state != ST_IDLE))
    else $error("block still idle after taking an item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(QUEUE_DEPTH))
    else $error("sample count beyond queue depth");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ((state == ST_RD_AVG) || (state == ST_RD_SPD)))
    else $error("divider finished outside a read");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.speed_valid) |->
      ((out_ch.period_ticks == '0) && !out_ch.sample_taken && !out_ch.stall_flag))
    else $error("read result carries capture or wrap fields");
`endif

endmodule
`default_nettype wire
